// ===== rtl/core/frie_pkg.sv =====
// Shared types and constants of the four-register instruction executor.
`timescale 1ns / 1ps
`default_nettype none

package frie_pkg;

    localparam int LINE_W            = 7;
    localparam int REG_W             = 16;
    localparam int NUM_REGS          = 4;
    localparam int REG_AW            = 2;
    localparam int CMD_W             = 4;
    localparam int PROGRAM_LINES_DEF = 128;
    localparam int QUEUE_DEPTH_DEF   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOP   = 4'd0,
        CMD_READ  = 4'd1,
        CMD_PRINT = 4'd2,
        CMD_MOV   = 4'd3,
        CMD_ADD   = 4'd4,
        CMD_SUB   = 4'd5,
        CMD_MUL   = 4'd6,
        CMD_DIV   = 4'd7,
        CMD_JMP   = 4'd8,
        CMD_JE    = 4'd9,
        CMD_JNE   = 4'd10,
        CMD_JG    = 4'd11,
        CMD_JGE   = 4'd12,
        CMD_JL    = 4'd13,
        CMD_JLE   = 4'd14,
        CMD_BAD   = 4'd15
    } t_cmd;

    typedef struct packed {
        logic is_bad;
        logic is_div;
        logic is_jump;
        logic writes_dst;
    } t_cls;

    typedef struct packed {
        t_cmd                     cmd;
        t_cls                     cls;
        logic                     src_is_imm;
        logic [REG_AW-1:0]        src_reg;
        logic signed [REG_W-1:0]  src_imm;
        logic                     second_is_imm;
        logic [REG_AW-1:0]        second_reg;
        logic signed [REG_W-1:0]  second_imm;
        logic [LINE_W-1:0]        jump_line;
        logic signed [REG_W-1:0]  read_value;
    } t_item;

    typedef struct packed {
        logic [LINE_W-1:0]        next_line;
        logic                     print_valid;
        logic signed [REG_W-1:0]  print_value;
        logic                     jump_taken;
        logic                     halted;
        logic                     divide_by_zero;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/core/four_register_instruction_executor.sv =====
// Top level of the four-register instruction executor.
// An instruction is taken when the back end is idle and the result queue has room;
// its registers are read, then it executes and its result is queued. A div with nonzero
// divisor waits for the iterative divider, one quotient bit per step, before finishing.
// One instruction is in the back end at a time; the next is taken only after it finishes.
// Reset: synchronous; regs read as zero; clears line counter, halt flag and both queues.
`timescale 1ns / 1ps
`default_nettype none

module four_register_instruction_executor #(
    parameter int PROGRAM_LINES = frie_pkg::PROGRAM_LINES_DEF,
    parameter int QUEUE_DEPTH   = frie_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [frie_pkg::CMD_W-1:0]        i_cmd,
    input  logic                              i_src_is_imm,
    input  logic [frie_pkg::REG_AW-1:0]       i_src_reg,
    input  logic signed [frie_pkg::REG_W-1:0] i_src_imm,
    input  logic                              i_second_is_imm,
    input  logic [frie_pkg::REG_AW-1:0]       i_second_reg,
    input  logic signed [frie_pkg::REG_W-1:0] i_second_imm,
    input  logic [frie_pkg::LINE_W-1:0]       i_jump_line,
    input  logic signed [frie_pkg::REG_W-1:0] i_read_value,
    output logic                              empty,
    input  logic                              pop,
    output logic [frie_pkg::LINE_W-1:0]       o_next_line,
    output logic                              o_print_valid,
    output logic signed [frie_pkg::REG_W-1:0] o_print_value,
    output logic                              o_jump_taken,
    output logic                              o_halted,
    output logic                              o_divide_by_zero
);

    import frie_pkg::*;

    t_item w_item;
    logic  w_item_empty;
    logic  w_item_pop;
    t_res  w_res;

    frie_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_src_is_imm    (i_src_is_imm),
        .i_src_reg       (i_src_reg),
        .i_src_imm       (i_src_imm),
        .i_second_is_imm (i_second_is_imm),
        .i_second_reg    (i_second_reg),
        .i_second_imm    (i_second_imm),
        .i_jump_line     (i_jump_line),
        .i_read_value    (i_read_value),
        .o_item          (w_item),
        .o_empty         (w_item_empty),
        .i_pop           (w_item_pop)
    );

    frie_back #(
        .PROGRAM_LINES (PROGRAM_LINES),
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_empty (w_item_empty),
        .o_item_pop   (w_item_pop),
        .o_res        (w_res),
        .empty        (empty),
        .pop          (pop)
    );

    assign o_next_line      = w_res.next_line;
    assign o_print_valid    = w_res.print_valid;
    assign o_print_value    = w_res.print_value;
    assign o_jump_taken     = w_res.jump_taken;
    assign o_halted         = w_res.halted;
    assign o_divide_by_zero = w_res.divide_by_zero;

endmodule

`default_nettype wire

// ===== rtl/core/frie_fifo.sv =====
// Small first-word-fall-through queue built from registers.
`timescale 1ns / 1ps
`default_nettype none

module frie_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/frie_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module frie_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/frie_front.sv =====
// Front end: accepts instructions, classifies them and queues them for execution.
`timescale 1ns / 1ps
`default_nettype none

module frie_front #(
    parameter int QUEUE_DEPTH = frie_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [frie_pkg::CMD_W-1:0]        i_cmd,
    input  logic                              i_src_is_imm,
    input  logic [frie_pkg::REG_AW-1:0]       i_src_reg,
    input  logic signed [frie_pkg::REG_W-1:0] i_src_imm,
    input  logic                              i_second_is_imm,
    input  logic [frie_pkg::REG_AW-1:0]       i_second_reg,
    input  logic signed [frie_pkg::REG_W-1:0] i_second_imm,
    input  logic [frie_pkg::LINE_W-1:0]       i_jump_line,
    input  logic signed [frie_pkg::REG_W-1:0] i_read_value,
    output frie_pkg::t_item                   o_item,
    output logic                              o_empty,
    input  logic                              i_pop
);

    import frie_pkg::*;

    t_item                  w_item;
    logic [$bits(t_item)-1:0] w_qdata;

    always_comb begin
        w_item                 = '0;
        w_item.cmd             = t_cmd'(i_cmd);
        w_item.cls.is_bad      = (w_item.cmd == CMD_BAD);
        w_item.cls.is_div      = (w_item.cmd == CMD_DIV);
        w_item.cls.is_jump     = (w_item.cmd inside {[CMD_JMP:CMD_JLE]});
        w_item.cls.writes_dst  = (w_item.cmd inside {CMD_READ, CMD_MOV, CMD_ADD,
                                                      CMD_SUB, CMD_MUL});
        w_item.src_is_imm      = i_src_is_imm;
        w_item.src_reg         = i_src_reg;
        w_item.src_imm         = i_src_imm;
        w_item.second_is_imm   = i_second_is_imm;
        w_item.second_reg      = i_second_reg;
        w_item.second_imm      = i_second_imm;
        w_item.jump_line       = i_jump_line;
        w_item.read_value      = i_read_value;
    end

    frie_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_item),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_data  (w_qdata),
        .o_empty (o_empty)
    );

    assign o_item = t_item'(w_qdata);

endmodule

`default_nettype wire

// ===== rtl/core/frie_div.sv =====
// Iterative signed 16-bit divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps
`default_nettype none

module frie_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [frie_pkg::REG_W-1:0] i_dividend,
    input  logic signed [frie_pkg::REG_W-1:0] i_divisor,
    output logic                              o_done,
    output logic signed [frie_pkg::REG_W-1:0] o_quot
);

    import frie_pkg::*;

    localparam int CNT_W = $clog2(REG_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [REG_W-1:0] r_quo;
    logic [REG_W-1:0] r_rem;
    logic [REG_W-1:0] r_dvs;
    logic             r_neg;
    logic [REG_W:0]   w_shift;
    logic [REG_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[REG_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = !w_diff[REG_W];
    assign o_done  = r_done;
    assign o_quot  = r_neg ? -$signed(r_quo) : $signed(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= w_ge ? w_diff[REG_W-1:0] : w_shift[REG_W-1:0];
            r_quo <= {r_quo[REG_W-2:0], w_ge};
        end else if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[REG_W-1] ? REG_W'(-i_dividend) : i_dividend;
            r_dvs <= i_divisor[REG_W-1] ? REG_W'(-i_divisor) : i_divisor;
            r_neg <= i_dividend[REG_W-1] ^ i_divisor[REG_W-1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/frie_back.sv =====
// Back end: register file, execution of one instruction at a time, result queue.
`timescale 1ns / 1ps
`default_nettype none

module frie_back #(
    parameter int PROGRAM_LINES = frie_pkg::PROGRAM_LINES_DEF,
    parameter int QUEUE_DEPTH   = frie_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  frie_pkg::t_item i_item,
    input  logic            i_item_empty,
    output logic            o_item_pop,
    output frie_pkg::t_res  o_res,
    output logic            empty,
    input  logic            pop
);

    import frie_pkg::*;

    localparam int LUT_N = (1 << LINE_W) + 1;
    localparam int LUT_W = LINE_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } t_state;

    t_state                  r_state;
    t_item                   r_cur;
    logic [LINE_W-1:0]       r_line;
    logic                    r_halt;
    logic [NUM_REGS-1:0]     r_valid;
    logic                    r_src_ok;
    logic                    r_dst_ok;

    logic [LINE_W-1:0]       w_mod [LUT_N];
    logic [REG_W-1:0]        w_rd_a;
    logic [REG_W-1:0]        w_rd_b;
    logic signed [REG_W-1:0] w_a;
    logic signed [REG_W-1:0] w_d;
    logic signed [REG_W-1:0] w_b;
    logic signed [2*REG_W-1:0] w_prod;
    logic signed [REG_W-1:0] w_wval;
    logic                    w_cond;
    logic                    w_stop;
    logic                    w_div_go;
    logic                    w_dz;
    logic [LINE_W-1:0]       w_seq;
    logic [LINE_W-1:0]       w_target;
    logic [LINE_W-1:0]       w_next;
    logic                    w_take;
    logic                    w_we;
    logic [REG_W-1:0]        w_wdata;
    logic                    w_div_done;
    logic signed [REG_W-1:0] w_quot;
    logic                    w_res_push;
    logic                    w_res_full;
    t_res                    w_res;
    logic [$bits(t_res)-1:0] w_res_q;

    for (genvar g = 0; g < LUT_N; g++) begin : g_mod
        assign w_mod[g] = LINE_W'(g % PROGRAM_LINES);
    end

    assign w_seq    = w_mod[{1'b0, r_line} + LUT_W'(1)];
    assign w_target = w_mod[{1'b0, r_cur.jump_line}];

    frie_ram #(
        .WIDTH (REG_W),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_cur.second_reg),
        .i_wdata   (w_wdata),
        .i_raddr_a (i_item.src_reg),
        .i_raddr_b (i_item.second_reg),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    frie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend (w_a),
        .i_divisor  (w_d),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_d    = r_dst_ok ? $signed(w_rd_b) : '0;
    assign w_a    = r_cur.src_is_imm ? r_cur.src_imm : (r_src_ok ? $signed(w_rd_a) : '0);
    assign w_b    = r_cur.second_is_imm ? r_cur.second_imm : w_d;
    assign w_prod = w_a * w_d;
    assign w_stop = r_halt || r_cur.cls.is_bad;
    assign w_take = (r_state == ST_IDLE) && !i_item_empty && !w_res_full;
    assign o_item_pop = w_take;

    always_comb begin
        w_wval = w_a;
        w_cond = 1'b0;
        case (r_cur.cmd)
            CMD_NOP:   w_wval = w_a;
            CMD_READ:  w_wval = r_cur.read_value;
            CMD_PRINT: w_wval = w_a;
            CMD_MOV:   w_wval = w_a;
            CMD_ADD:   w_wval = w_a + w_d;
            CMD_SUB:   w_wval = w_d - w_a;
            CMD_MUL:   w_wval = w_prod[REG_W-1:0];
            CMD_DIV:   w_wval = w_a;
            CMD_JMP:   w_cond = 1'b1;
            CMD_JE:    w_cond = (w_a == w_b);
            CMD_JNE:   w_cond = (w_a != w_b);
            CMD_JG:    w_cond = (w_a > w_b);
            CMD_JGE:   w_cond = (w_a >= w_b);
            CMD_JL:    w_cond = (w_a < w_b);
            CMD_JLE:   w_cond = (w_a <= w_b);
            CMD_BAD:   w_cond = 1'b0;
            default:   w_cond = 1'b0;
        endcase
    end

    assign w_div_go = (r_state == ST_EXEC) && !w_stop && r_cur.cls.is_div && (w_d != '0);
    assign w_dz     = !w_stop && r_cur.cls.is_div && (w_d == '0);
    assign w_next   = w_stop ? r_line : ((!w_stop && w_cond) ? w_target : w_seq);

    always_comb begin
        w_we       = 1'b0;
        w_wdata    = w_wval;
        w_res_push = 1'b0;
        w_res      = '0;
        case (r_state)
            ST_EXEC: begin
                w_we                 = !w_stop && r_cur.cls.writes_dst;
                w_res_push           = !w_div_go;
                w_res.next_line      = w_next;
                w_res.print_valid    = !w_stop && (r_cur.cmd == CMD_PRINT);
                w_res.print_value    = (!w_stop && (r_cur.cmd == CMD_PRINT)) ? w_a : '0;
                w_res.jump_taken     = !w_stop && w_cond;
                w_res.halted         = w_stop;
                w_res.divide_by_zero = w_dz;
            end
            ST_DIV: begin
                w_we            = w_div_done;
                w_wdata         = w_quot;
                w_res_push      = w_div_done;
                w_res.next_line = r_line;
            end
            default: begin
                w_we       = 1'b0;
                w_res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_line  <= '0;
            r_halt  <= 1'b0;
            r_valid <= '0;
        end else begin
            if (w_we) begin
                r_valid[r_cur.second_reg] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_line  <= w_next;
                    r_halt  <= w_stop;
                    r_state <= w_div_go ? ST_DIV : ST_IDLE;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cur    <= i_item;
            r_src_ok <= r_valid[i_item.src_reg];
            r_dst_ok <= r_valid[i_item.second_reg];
        end
    end

    frie_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_q),
        .o_empty (empty)
    );

    assign o_res = t_res'(w_res_q);

endmodule

`default_nettype wire

// ===== rtl/core/frie_checker.sv =====
// Port-level checks of the instruction executor and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module frie_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic [frie_pkg::LINE_W-1:0]       o_next_line,
    input logic                              o_print_valid,
    input logic signed [frie_pkg::REG_W-1:0] o_print_value,
    input logic                              o_jump_taken,
    input logic                              o_halted,
    input logic                              o_divide_by_zero
);

    import frie_pkg::*;

    logic              r_seen_halt;
    logic [LINE_W-1:0] r_last_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
            r_last_line <= '0;
        end else if (pop && !empty) begin
            r_seen_halt <= r_seen_halt | o_halted;
            r_last_line <= o_next_line;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && r_seen_halt) |-> o_halted)
        else $error("halt flag dropped after being set");

    a_halt_holds_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_halted) |-> (o_next_line == r_last_line))
        else $error("halted result moved the line counter");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_halted) |-> !o_print_valid && !o_jump_taken && !o_divide_by_zero)
        else $error("halted result shows activity");

    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_print_valid) |-> (o_print_value == '0))
        else $error("print value nonzero without print");

endmodule

bind four_register_instruction_executor frie_checker u_frie_checker (.*);

`default_nettype wire

// ===== tb/tb_four_register_instruction_executor.sv =====
// Self-checking testbench for the four-register instruction executor.
`timescale 1ns / 1ps
`default_nettype none

module tb_four_register_instruction_executor;
    import frie_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 750;
    localparam int HOLD_OFF       = 400;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic [REG_AW-1:0] REG_AX = 2'd0;
    localparam logic [REG_AW-1:0] REG_BX = 2'd1;
    localparam logic [REG_AW-1:0] REG_CX = 2'd2;
    localparam logic [REG_AW-1:0] REG_DX = 2'd3;

    typedef struct packed {
        t_cmd                    cmd;
        logic                    src_is_imm;
        logic [REG_AW-1:0]       src_reg;
        logic signed [REG_W-1:0] src_imm;
        logic                    second_is_imm;
        logic [REG_AW-1:0]       second_reg;
        logic signed [REG_W-1:0] second_imm;
        logic [LINE_W-1:0]       jump_line;
        logic signed [REG_W-1:0] read_value;
    } t_instr;

    class exec_scoreboard;
        logic signed [REG_W-1:0] arch_regs [NUM_REGS];
        logic [LINE_W-1:0]       line_ctr;
        bit                      halt_seen;
        t_res                    pending_results [$];
        int                      errors;

        function new();
            foreach (arch_regs[k]) arch_regs[k] = '0;
            line_ctr  = '0;
            halt_seen = 1'b0;
            errors    = 0;
        endfunction

        function void note_instruction(t_instr it);
            logic signed [REG_W-1:0] a;
            logic signed [REG_W-1:0] d;
            logic signed [REG_W-1:0] b;
            logic signed [31:0]      wide;
            logic [LINE_W-1:0]       nxt;
            bit                      cond;
            t_res                    want;
            a    = it.src_is_imm ? it.src_imm : arch_regs[it.src_reg];
            d    = arch_regs[it.second_reg];
            b    = it.second_is_imm ? it.second_imm : d;
            nxt  = LINE_W'((int'(line_ctr) + 1) % PROGRAM_LINES_DEF);
            cond = 1'b0;
            want = '0;
            if (halt_seen || it.cmd == CMD_BAD) begin
                halt_seen = 1'b1;
                nxt       = line_ctr;
            end else begin
                case (it.cmd)
                    CMD_READ:  arch_regs[it.second_reg] = it.read_value;
                    CMD_PRINT: begin
                        want.print_valid = 1'b1;
                        want.print_value = a;
                    end
                    CMD_MOV:   arch_regs[it.second_reg] = a;
                    CMD_ADD:   arch_regs[it.second_reg] = REG_W'(a + d);
                    CMD_SUB:   arch_regs[it.second_reg] = REG_W'(d - a);
                    CMD_MUL: begin
                        wide = a * d;
                        arch_regs[it.second_reg] = wide[REG_W-1:0];
                    end
                    CMD_DIV: begin
                        if (d == 0) begin
                            want.divide_by_zero = 1'b1;
                        end else begin
                            wide = int'(a) / int'(d);
                            arch_regs[it.second_reg] = wide[REG_W-1:0];
                        end
                    end
                    CMD_JMP:   cond = 1'b1;
                    CMD_JE:    cond = (a == b);
                    CMD_JNE:   cond = (a != b);
                    CMD_JG:    cond = (a > b);
                    CMD_JGE:   cond = (a >= b);
                    CMD_JL:    cond = (a < b);
                    CMD_JLE:   cond = (a <= b);
                    default: ;
                endcase
                if (cond) begin
                    want.jump_taken = 1'b1;
                    nxt = LINE_W'(int'(it.jump_line) % PROGRAM_LINES_DEF);
                end
            end
            line_ctr       = nxt;
            want.next_line = nxt;
            want.halted    = halt_seen;
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                $error("result with no instruction pending: next_line %0d", got.next_line);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("next_line", int'(want.next_line), int'(got.next_line));
            compare_field("print_valid", int'(want.print_valid), int'(got.print_valid));
            compare_field("print_value", int'(want.print_value), int'(got.print_value));
            compare_field("jump_taken", int'(want.jump_taken), int'(got.jump_taken));
            compare_field("halted", int'(want.halted), int'(got.halted));
            compare_field("divide_by_zero", int'(want.divide_by_zero),
                          int'(got.divide_by_zero));
        endfunction
    endclass

    logic   i_clk    = 1'b0;
    logic   i_rst_n  = 1'b0;
    logic   push     = 1'b0;
    logic   pop      = 1'b0;
    t_instr drv_item = '0;
    logic   full;
    logic   empty;
    logic [LINE_W-1:0]       o_next_line;
    logic                    o_print_valid;
    logic signed [REG_W-1:0] o_print_value;
    logic                    o_jump_taken;
    logic                    o_halted;
    logic                    o_divide_by_zero;
    t_res                    seen_res;

    exec_scoreboard sb;
    int             n_popped    = 0;
    int             idle_cycles = 0;
    bit             held_off    = 1'b0;

    always #4 i_clk = ~i_clk;

    four_register_instruction_executor dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_cmd            (drv_item.cmd),
        .i_src_is_imm     (drv_item.src_is_imm),
        .i_src_reg        (drv_item.src_reg),
        .i_src_imm        (drv_item.src_imm),
        .i_second_is_imm  (drv_item.second_is_imm),
        .i_second_reg     (drv_item.second_reg),
        .i_second_imm     (drv_item.second_imm),
        .i_jump_line      (drv_item.jump_line),
        .i_read_value     (drv_item.read_value),
        .empty            (empty),
        .pop              (pop),
        .o_next_line      (o_next_line),
        .o_print_valid    (o_print_valid),
        .o_print_value    (o_print_value),
        .o_jump_taken     (o_jump_taken),
        .o_halted         (o_halted),
        .o_divide_by_zero (o_divide_by_zero)
    );

    assign seen_res = {o_next_line, o_print_valid, o_print_value,
                       o_jump_taken, o_halted, o_divide_by_zero};

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_instruction(drv_item);
            if (pop && !empty) begin
                sb.check_result(seen_res);
                n_popped <= n_popped + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles < WATCHDOG_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [REG_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            case ($urandom_range(0, 4))
                0:       return 16'sh0000;
                1:       return 16'sh0001;
                2:       return 16'shffff;
                3:       return 16'sh7fff;
                default: return 16'sh8000;
            endcase
        end
        if (r < 6) return REG_W'(int'($urandom_range(0, 16)) - 8);
        return REG_W'($urandom());
    endfunction

    function automatic t_instr rand_item();
        t_instr it;
        it.cmd           = t_cmd'(CMD_W'($urandom_range(CMD_NOP, CMD_JLE)));
        it.src_is_imm    = 1'($urandom_range(0, 1));
        it.src_reg       = REG_AW'($urandom_range(0, NUM_REGS - 1));
        it.src_imm       = pick_value();
        it.second_is_imm = 1'($urandom_range(0, 1));
        it.second_reg    = REG_AW'($urandom_range(0, NUM_REGS - 1));
        it.second_imm    = ($urandom_range(0, 3) == 0) ? it.src_imm : pick_value();
        it.jump_line     = LINE_W'($urandom_range(0, 127));
        it.read_value    = pick_value();
        return it;
    endfunction

    function automatic t_instr make_op(t_cmd c, logic s_is_imm, logic [REG_AW-1:0] s_reg,
                                       logic signed [REG_W-1:0] s_imm,
                                       logic [REG_AW-1:0] dst);
        t_instr it;
        it            = rand_item();
        it.cmd        = c;
        it.src_is_imm = s_is_imm;
        it.src_reg    = s_reg;
        it.src_imm    = s_imm;
        it.second_reg = dst;
        return it;
    endfunction

    task automatic issue(input t_instr it, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push     <= 1'b1;
        drv_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = ((n_popped % 128) < 32) ? 0 : pick_gap();
            if (!held_off && n_popped >= 150) begin
                gap      = HOLD_OFF;
                held_off = 1'b1;
            end
            repeat (gap) begin
                @(negedge i_clk);
                pop <= 1'b0;
            end
            @(negedge i_clk);
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin
        t_instr it;
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(make_op(CMD_NOP, 1'b0, REG_AX, 16'sh0000, REG_AX), pick_gap());
        issue(make_op(CMD_DIV, 1'b1, REG_AX, 16'sh0005, REG_DX), pick_gap());
        it = make_op(CMD_READ, 1'b0, REG_AX, 16'sh0000, REG_AX);
        it.read_value = 16'sh7fff;
        issue(it, pick_gap());
        it = make_op(CMD_READ, 1'b0, REG_AX, 16'sh0000, REG_BX);
        it.read_value = 16'sh8000;
        issue(it, pick_gap());
        issue(make_op(CMD_PRINT, 1'b0, REG_AX, 16'sh0000, REG_CX), pick_gap());
        issue(make_op(CMD_PRINT, 1'b1, REG_DX, 16'sh8000, REG_CX), pick_gap());
        issue(make_op(CMD_ADD, 1'b1, REG_CX, 16'sh0001, REG_AX), pick_gap());
        issue(make_op(CMD_SUB, 1'b1, REG_CX, 16'sh0001, REG_BX), pick_gap());
        issue(make_op(CMD_MOV, 1'b1, REG_AX, 16'sd300, REG_CX), pick_gap());
        issue(make_op(CMD_MUL, 1'b0, REG_CX, 16'sh0000, REG_CX), pick_gap());
        issue(make_op(CMD_MOV, 1'b1, REG_AX, 16'shffff, REG_DX), pick_gap());
        issue(make_op(CMD_DIV, 1'b0, REG_AX, 16'sh0000, REG_DX), pick_gap());
        issue(make_op(CMD_MOV, 1'b1, REG_AX, 16'sd7, REG_CX), pick_gap());
        issue(make_op(CMD_DIV, 1'b1, REG_AX, -16'sd100, REG_CX), pick_gap());
        it = make_op(CMD_JMP, 1'b0, REG_AX, 16'sh0000, REG_AX);
        it.jump_line = 7'd127;
        issue(it, pick_gap());
        issue(make_op(CMD_NOP, 1'b0, REG_AX, 16'sh0000, REG_AX), pick_gap());
        it = make_op(CMD_JE, 1'b0, REG_AX, 16'sh0000, REG_AX);
        it.second_is_imm = 1'b0;
        issue(it, pick_gap());
        it = make_op(CMD_JNE, 1'b0, REG_AX, 16'sh0000, REG_AX);
        it.second_is_imm = 1'b0;
        issue(it, pick_gap());
        it = make_op(CMD_JG, 1'b1, REG_AX, 16'sh7fff, REG_AX);
        it.second_is_imm = 1'b1;
        it.second_imm    = 16'sh8000;
        issue(it, pick_gap());
        it = make_op(CMD_JGE, 1'b1, REG_AX, 16'sh8000, REG_AX);
        it.second_is_imm = 1'b1;
        it.second_imm    = 16'sh8000;
        issue(it, pick_gap());
        it = make_op(CMD_JL, 1'b1, REG_AX, 16'sh7fff, REG_AX);
        it.second_is_imm = 1'b1;
        it.second_imm    = 16'sh8000;
        issue(it, pick_gap());
        it = make_op(CMD_JLE, 1'b1, REG_AX, 16'sh8000, REG_AX);
        it.second_is_imm = 1'b1;
        it.second_imm    = 16'sh7fff;
        issue(it, pick_gap());

        for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
            issue(rand_item(), ((idx % 100) < 25) ? 0 : pick_gap());
        end

        issue(make_op(CMD_BAD, 1'b0, REG_AX, 16'sh0000, REG_AX), pick_gap());
        issue(make_op(CMD_ADD, 1'b1, REG_AX, 16'sh0001, REG_AX), pick_gap());
        it = make_op(CMD_JMP, 1'b0, REG_AX, 16'sh0000, REG_AX);
        it.jump_line = 7'd0;
        issue(it, pick_gap());
        @(negedge i_clk);
        push <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
